>>> src/fbpa_pkg.sv
// Shared types, constants and register map of the fixed block pool allocator.
package fbpa_pkg;

   localparam int ADDR_W = 32;
   localparam int SIZE_W = 16;
   localparam int ESIZE_W = SIZE_W + 1;
   localparam int CNT_W = 7;
   localparam int BIDX_W = 6;
   localparam int PROD_W = CNT_W + ESIZE_W;
   localparam int REG_W = 2;
   localparam int SCAN_W = 8;
   localparam int SEL_W = 3;
   localparam int DEF_MAX_BLOCKS = 64;
   localparam int SIZE_ROUND = 3;
   localparam logic [SIZE_W-1:0] DEF_BLOCK_SIZE = SIZE_W'(4);

   localparam logic [REG_W-1:0] REG_POOL_BASE = 2'd0;
   localparam logic [REG_W-1:0] REG_BLOCK_SIZE = 2'd1;
   localparam logic [REG_W-1:0] REG_BLOCK_COUNT = 2'd2;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_ALLOCATED = 2'd0,
      ST_FULL      = 2'd1,
      ST_FREED     = 2'd2,
      ST_IGNORED   = 2'd3
   } rsp_status_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      rsp_status_type    status;
      logic [ADDR_W-1:0] address_res;
      logic [BIDX_W-1:0] block_index;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic div_start;
      logic scan;
      logic mul;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_is_free;
      logic scan_found;
      logic scan_last;
      logic div_done;
   } ctrl_status_type;

endpackage

>>> src/fbpa_div.sv
// Restoring divider, one quotient bit per cycle, for the free address lookup.
module fbpa_div
   import fbpa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [ADDR_W-1:0]  dividend,
   input  logic [ESIZE_W-1:0] divisor,
   output logic               done,
   output logic [ADDR_W-1:0]  quotient
);

   localparam int STEP_W = $clog2(ADDR_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [ESIZE_W-1:0]  rem_ff, rem_in;
   logic [ESIZE_W-1:0]  dvs_ff, dvs_in;
   logic [ADDR_W-1:0]   quo_ff, quo_in;
   logic [ESIZE_W:0]    rem_shift;
   logic [ESIZE_W:0]    rem_diff;
   logic                fits;

   assign rem_shift = {rem_ff, quo_ff[ADDR_W-1]};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};
   assign fits      = rem_shift >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // zero divisor always fits, so the quotient comes out all ones
         rem_in  = fits ? rem_diff[ESIZE_W-1:0] : rem_shift[ESIZE_W-1:0];
         quo_in  = {quo_ff[ADDR_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(ADDR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> src/fbpa_dp.sv
// Datapath: configuration registers, in-use flags, group scanner, multiplier and result word.
module fbpa_dp
   import fbpa_pkg::*;
#(
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [REG_W-1:0]   csr_index,
   input  logic [ADDR_W-1:0]  csr_wdata,
   input  req_type            req_data,
   input  ctrl_cmd_type       cmd,
   output ctrl_status_type    sts,
   output rsp_type            rsp_data
);

   // the count register cannot address more than this many blocks
   localparam int CAP = (MAX_BLOCKS < (2 ** CNT_W) - 1) ? MAX_BLOCKS : (2 ** CNT_W) - 1;
   localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAP);
   localparam int NGRP = (CAP + SCAN_W - 1) / SCAN_W;
   localparam int NF = NGRP * SCAN_W;
   localparam int IDX_W = $clog2(NF);
   localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;

   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [NF-1:0]      flags_ff, flags_in;
   logic [GRP_W-1:0]   grp_ff, grp_in;
   logic               is_free_ff, is_free_in;
   logic               found_ff, found_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   rsp_type            rsp_ff, rsp_in;

   logic [ESIZE_W-1:0] size_eff;
   logic [CNT_W-1:0]   count_eff;
   logic [IDX_W-1:0]   grp_base;
   logic [SCAN_W-1:0]  grp_flags;
   logic [SCAN_W-1:0]  avail;
   logic [SEL_W-1:0]   scan_sel;
   logic [CNT_W-1:0]   scan_idx;
   logic [ADDR_W-1:0]  offset;
   logic [ADDR_W-1:0]  div_quo;
   logic               div_done;
   logic               in_range;

   assign size_eff  = ({1'b0, size_ff} + ESIZE_W'(SIZE_ROUND)) & ~ESIZE_W'(SIZE_ROUND);
   assign count_eff = (count_ff > CAP_V) ? CAP_V : count_ff;
   assign offset    = req_data.address - base_ff;

   fbpa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (offset),
      .divisor  (size_eff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign in_range = div_quo < ADDR_W'(count_eff);

   // one group of flags per cycle; blocks at or above the count read as taken
   assign grp_base  = IDX_W'({grp_ff, SEL_W'(0)});
   assign grp_flags = flags_ff[grp_base +: SCAN_W];

   always_comb begin
      for (int j = 0; j < SCAN_W; j++) begin
         avail[j] = !grp_flags[j] && (CNT_W'({grp_ff, SEL_W'(j)}) < count_eff);
      end
   end

   always_comb begin
      scan_sel = '0;
      for (int j = SCAN_W - 1; j >= 0; j--) begin
         if (avail[j]) begin
            scan_sel = SEL_W'(j);
         end
      end
   end

   assign scan_idx = CNT_W'({grp_ff, scan_sel});

   assign sts.req_is_free = req_data.cmd == CMD_FREE;
   assign sts.scan_found  = |avail;
   assign sts.scan_last   = grp_ff == GRP_W'(NGRP - 1);
   assign sts.div_done    = div_done;

   always_comb begin
      base_in    = base_ff;
      size_in    = size_ff;
      count_in   = count_ff;
      flags_in   = flags_ff;
      grp_in     = grp_ff;
      is_free_in = is_free_ff;
      found_in   = found_ff;
      idx_in     = idx_ff;
      prod_in    = prod_ff;
      rsp_in     = rsp_ff;

      if (csr_we) begin
         case (csr_index)
            REG_POOL_BASE:   base_in  = csr_wdata;
            REG_BLOCK_SIZE:  size_in  = csr_wdata[SIZE_W-1:0];
            REG_BLOCK_COUNT: count_in = csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end

      if (cmd.capture) begin
         is_free_in = req_data.cmd == CMD_FREE;
         grp_in     = '0;
         found_in   = 1'b0;
      end

      if (cmd.scan) begin
         if (|avail) begin
            found_in = 1'b1;
            idx_in   = scan_idx;
            flags_in[scan_idx[IDX_W-1:0]] = 1'b1;
         end else begin
            grp_in = grp_ff + GRP_W'(1);
         end
      end

      if (cmd.mul) begin
         prod_in = PROD_W'(idx_ff) * PROD_W'(size_eff);
      end

      if (cmd.load_rsp) begin
         if (is_free_ff) begin
            if (in_range) begin
               flags_in[div_quo[IDX_W-1:0]] = 1'b0;
               rsp_in = '{ST_FREED, '0, div_quo[BIDX_W-1:0]};
            end else begin
               rsp_in = '{ST_IGNORED, '0, '0};
            end
         end else if (found_ff) begin
            rsp_in = '{ST_ALLOCATED, base_ff + ADDR_W'(prod_ff), idx_ff[BIDX_W-1:0]};
         end else begin
            rsp_in = '{ST_FULL, '0, '0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         size_ff  <= DEF_BLOCK_SIZE;
         count_ff <= '0;
         flags_ff <= '0;
      end else begin
         base_ff  <= base_in;
         size_ff  <= size_in;
         count_ff <= count_in;
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff     <= grp_in;
      is_free_ff <= is_free_in;
      found_ff   <= found_in;
      idx_ff     <= idx_in;
      prod_ff    <= prod_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

>>> src/fbpa_ctrl.sv
// Controller: sequences one word through scan or divide and owns both handshakes.
module fbpa_ctrl
   import fbpa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  ctrl_status_type sts,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SCAN = 5'b00010,
      S_MUL  = 5'b00100,
      S_DIV  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (sts.req_is_free) begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_found) begin
               state_in = S_MUL;
            end else if (sts.scan_last) begin
               state_in = S_DONE;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DONE;
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output word is free or leaving this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a word is still in work");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide wait");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid)
      else $error("result loaded but not presented");

   a_found_to_mul: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN && sts.scan_found |=> state_ff == S_MUL)
      else $error("free block found but address not computed");

endmodule

>>> src/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator.
//
// Usage: program pool_base, block_size and block_count through the csr_
// write port while the block is idle. Each request word on req_ (cmd and
// address) gives exactly one response word on rsp_ (status, address_res,
// block_index). Both channels use valid/ready.
// An allocate scans the in-use flags eight blocks per cycle, then forms
// index * size in the multiply state and adds base when the response is
// loaded; with no free block it goes straight to the response.
// A free runs a one-bit-per-cycle 32-bit divider on (address - base) by the
// rounded size to find the block index.
// One word is in work at a time: the next request is taken in the cycle
// after the response has been loaded.
// The response sits in an output register; a stalled receiver only holds
// the next result back, and the next request is still accepted meanwhile.
// Reset clears every in-use flag at once and sets base 0, size 4, count 0.
module fixed_block_pool_allocator
   import fbpa_pkg::*;
#(
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [REG_W-1:0]  csr_index,
   input  logic [ADDR_W-1:0] csr_wdata
);

   ctrl_cmd_type    cmd;
   ctrl_status_type sts;

   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fbpa_dp #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule
